### design/pars_pkg.sv
// Package for the progression-add / range-sum store.
// Holds item kind codes, sequencer states, walk and combine step codes and the walk delta function; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pars_pkg;

   localparam int DATA_W  = 64;
   localparam int SUM_W   = 63;
   localparam int VALUE_W = 20;
   localparam int INDEX_W = 11;
   localparam int PROD_W  = 22;
   localparam int TREE_W  = 3;
   localparam int WALK_W  = 4;
   localparam int STEP_W  = 2;
   localparam int TREE_COUNT = 6;

   typedef logic [1:0] kind_type;
   localparam kind_type KIND_LOAD  = 2'd0;
   localparam kind_type KIND_ADD   = 2'd1;
   localparam kind_type KIND_QUERY = 2'd2;

   // Walks of a progression add: tree and position (low or high plus one)
   localparam logic [WALK_W-1:0] W_A_LO = 4'd0;
   localparam logic [WALK_W-1:0] W_A_HI = 4'd1;
   localparam logic [WALK_W-1:0] W_B_LO = 4'd2;
   localparam logic [WALK_W-1:0] W_B_HI = 4'd3;
   localparam logic [WALK_W-1:0] W_C_LO = 4'd4;
   localparam logic [WALK_W-1:0] W_C_HI = 4'd5;
   localparam logic [WALK_W-1:0] W_D_LO = 4'd6;
   localparam logic [WALK_W-1:0] W_D_HI = 4'd7;
   localparam logic [WALK_W-1:0] W_E_LO = 4'd8;
   localparam logic [WALK_W-1:0] W_E_HI = 4'd9;

   localparam logic [TREE_W-1:0] TREE_BASE       = 3'd5;
   localparam logic [TREE_W-1:0] QUERY_LAST_WALK = 3'd5;

   localparam logic [STEP_W-1:0] CMB_QUAD  = 2'd0;
   localparam logic [STEP_W-1:0] CMB_LIN   = 2'd1;
   localparam logic [STEP_W-1:0] CMB_HALF  = 2'd2;
   localparam logic [STEP_W-1:0] CMB_FINAL = 2'd3;

   typedef enum logic [7:0] {
      ST_CLEAR   = 8'b0000_0001,
      ST_IDLE    = 8'b0000_0010,
      ST_START   = 8'b0000_0100,
      ST_READ    = 8'b0000_1000,
      ST_USE     = 8'b0001_0000,
      ST_NEXT    = 8'b0010_0000,
      ST_COMBINE = 8'b0100_0000,
      ST_FINISH  = 8'b1000_0000
   } state_type;

   // Delta added by each walk of a progression add
   function automatic logic [DATA_W-1:0] add_delta(
      input logic [WALK_W-1:0] walk,
      input logic [DATA_W-1:0] l,
      input logic [DATA_W-1:0] h,
      input logic [DATA_W-1:0] p1,
      input logic [DATA_W-1:0] p2
   );
      logic [DATA_W-1:0] d;
      case (walk)
         W_A_LO:  d = 64'd1;
         W_A_HI:  d = '1;
         W_B_LO:  d = 64'd0 - (l - 64'd1);
         W_B_HI:  d = h;
         W_C_LO:  d = 64'd1;
         W_C_HI:  d = '1;
         W_D_LO:  d = 64'd0 - ((l << 1) - 64'd1);
         W_D_HI:  d = (l << 1) - 64'd1;
         W_E_LO:  d = p1;
         W_E_HI:  d = p2 - p1;
         default: d = '0;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

### design/pars_mac.sv
// Shared multiply-add unit of the prefix combine: y = a * b + c, modulo 2^64.
// Depends on pars_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pars_mac
   import pars_pkg::*;
#(
   parameter int B_W = 12
) (
   input  wire logic [DATA_W-1:0] mac_a,
   input  wire logic [B_W-1:0]    mac_b,
   input  wire logic [DATA_W-1:0] mac_c,
   output logic      [DATA_W-1:0] mac_y
);

   logic [DATA_W-1:0] prod;

   assign prod  = mac_a * {{(DATA_W-B_W){1'b0}}, mac_b};
   assign mac_y = prod + mac_c;

endmodule

`default_nettype wire

### design/progression_add_range_sum_fenwick.sv
// Progression-add / range-sum store over ARRAY_SIZE elements, indexed from 1.
// Request words (req_kind, req_range_low, req_range_high, req_load_value) are
// taken when req_valid is high and req_stall low; req_stall is high whenever
// the sequencer is busy. A load adds a value at one index, a progression add
// adds 1, 2, 3, ... over [low, high], and a query returns one rsp_ word with
// the sum over [low, high] modulo 2^63. Loads and adds give no response.
// The element store is six Fenwick trees in one single-port style memory; one
// walk visits at most log2(ARRAY_SIZE)+1 nodes, each read and then accumulated
// or written back. A load is one walk; an add is ten walks; a query is
// twelve walks plus two four-step combines on the shared multiply-add.
// After reset the block sweeps all 6 * 2^ceil(log2(ARRAY_SIZE+1)) memory
// words to zero (12288 at N = 1024), one word a cycle, before it takes
// a request. A query result sits in an output register; while rsp_stall is
// high the word holds and the block keeps taking loads and adds; a second
// query waits at its end until the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module progression_add_range_sum_fenwick
   import pars_pkg::*;
#(
   parameter int ARRAY_SIZE = 1024
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_kind,
   input  wire logic [INDEX_W-1:0] req_range_low,
   input  wire logic [INDEX_W-1:0] req_range_high,
   input  wire logic [VALUE_W-1:0] req_load_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [SUM_W-1:0]        rsp_range_sum
);

   localparam int IW        = $clog2(ARRAY_SIZE + 1);
   localparam int XW        = IW + 1;
   localparam int ADDR_W    = TREE_W + IW;
   localparam int MEM_DEPTH = TREE_COUNT << IW;
   localparam logic [31:0] N_MAX = 32'(ARRAY_SIZE);
   localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(MEM_DEPTH - 1);
   localparam logic [WALK_W-1:0] ADD_LAST_WALK = W_E_HI;

   // Tree memory
   logic [DATA_W-1:0] tree_mem [0:MEM_DEPTH-1];
   logic [DATA_W-1:0] rd_data_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [DATA_W-1:0] mem_wdata;

   // Sequencer and payload registers
   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  clr_ff, clr_in;
   kind_type           mode_ff, mode_in;
   logic [WALK_W-1:0]  walk_ff, walk_in;
   logic               phase_ff, phase_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [XW-1:0]      x_ff, x_in;
   logic [XW-1:0]      lo_ff, lo_in, hi_ff, hi_in;
   logic [VALUE_W-1:0] val_ff, val_in;
   logic [PROD_W-1:0]  p1_ff, p1_in, p2_ff, p2_in;
   logic [DATA_W-1:0]  acc_ff, acc_in;
   logic [DATA_W-1:0]  phi_ff, phi_in;
   logic [DATA_W-1:0]  coef_ff [0:TREE_COUNT-1];
   logic               coef_we;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]   rsp_sum_ff, rsp_sum_in;

   // Datapath helpers
   logic               upd;
   logic [TREE_W-1:0]  tree_sel;
   logic [XW-1:0]      walk_pos, lowbit, x_up, x_dn;
   logic               pos_ok;
   logic [DATA_W-1:0]  delta;
   logic [DATA_W-1:0]  mac_a, mac_c, mac_y;
   logic [31:0]        lo_w, hi_w, lc_w, hc_w;
   logic [INDEX_W-1:0] span;
   logic               req_take;

   pars_mac #(.B_W(XW)) u_mac (
      .mac_a (mac_a),
      .mac_b (walk_pos),
      .mac_c (mac_c),
      .mac_y (mac_y)
   );

   assign req_stall     = (state_ff != ST_IDLE);
   assign req_take      = req_valid && (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_range_sum = rsp_sum_ff;

   assign upd    = (mode_ff != KIND_QUERY);
   assign lowbit = x_ff & (~x_ff + XW'(1));
   assign x_up   = x_ff + lowbit;
   assign x_dn   = x_ff - lowbit;
   assign lo_w   = 32'(req_range_low);
   assign hi_w   = 32'(req_range_high);
   assign hc_w   = (hi_w > N_MAX) ? N_MAX : hi_w;
   assign lc_w   = (lo_w == 32'd0) ? 32'd1 : lo_w;
   assign span   = req_range_high - req_range_low;

   always_comb begin
      case (mode_ff)
         KIND_LOAD: begin
            tree_sel = TREE_BASE;
            walk_pos = lo_ff;
            delta    = 64'(val_ff);
         end
         KIND_ADD: begin
            tree_sel = walk_ff[TREE_W:1];
            walk_pos = walk_ff[0] ? (hi_ff + XW'(1)) : lo_ff;
            delta    = add_delta(walk_ff, 64'(lo_ff), 64'(hi_ff), 64'(p1_ff), 64'(p2_ff));
         end
         default: begin
            tree_sel = walk_ff[TREE_W-1:0];
            walk_pos = phase_ff ? (lo_ff - XW'(1)) : hi_ff;
            delta    = '0;
         end
      endcase
   end

   assign pos_ok = (walk_pos != '0) && (upd ? (32'(walk_pos) <= N_MAX) : 1'b1);
   assign mem_raddr = {tree_sel, x_ff[IW-1:0]};

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      mode_in      = mode_ff;
      walk_in      = walk_ff;
      phase_in     = phase_ff;
      step_in      = step_ff;
      x_in         = x_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      val_in       = val_ff;
      p1_in        = p1_ff;
      p2_in        = p2_ff;
      acc_in       = acc_ff;
      phi_in       = phi_ff;
      coef_we      = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_sum_in   = rsp_sum_ff;
      mem_we       = 1'b0;
      mem_waddr    = mem_raddr;
      mem_wdata    = rd_data_ff + delta;
      mac_a        = coef_ff[0];
      mac_c        = acc_ff;

      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + ADDR_W'(1);
            if (clr_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               mode_in  = req_kind;
               walk_in  = '0;
               phase_in = 1'b0;
               val_in   = req_load_value;
               p1_in    = PROD_W'(req_range_low) * PROD_W'(req_range_low - INDEX_W'(1));
               p2_in    = PROD_W'(span) * PROD_W'(span + INDEX_W'(1));
               case (req_kind)
                  KIND_LOAD: begin
                     lo_in = lo_w[XW-1:0];
                     if (lo_w != 32'd0 && lo_w <= N_MAX) begin
                        state_in = ST_START;
                     end
                  end
                  KIND_ADD: begin
                     lo_in = lo_w[XW-1:0];
                     hi_in = hi_w[XW-1:0];
                     if (lo_w != 32'd0 && lo_w <= hi_w && hi_w <= N_MAX) begin
                        state_in = ST_START;
                     end
                  end
                  KIND_QUERY: begin
                     lo_in = lc_w[XW-1:0];
                     hi_in = hc_w[XW-1:0];
                     if (lc_w <= hc_w) begin
                        state_in = ST_START;
                     end else begin
                        acc_in   = '0;
                        state_in = ST_FINISH;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_START: begin
            x_in     = walk_pos;
            acc_in   = '0;
            state_in = pos_ok ? ST_READ : ST_NEXT;
         end
         ST_READ: begin
            state_in = ST_USE;
         end
         ST_USE: begin
            if (upd) begin
               // write back and climb toward the root
               mem_we = 1'b1;
               x_in   = x_up;
               state_in = (32'(x_up) > N_MAX) ? ST_NEXT : ST_READ;
            end else begin
               // accumulate and drop the lowest set bit
               acc_in = acc_ff + rd_data_ff;
               x_in   = x_dn;
               state_in = (x_dn == '0) ? ST_NEXT : ST_READ;
            end
         end
         ST_NEXT: begin
            if (upd) begin
               if (mode_ff == KIND_LOAD || walk_ff == ADD_LAST_WALK) begin
                  state_in = ST_IDLE;
               end else begin
                  walk_in  = walk_ff + WALK_W'(1);
                  state_in = ST_START;
               end
            end else begin
               coef_we = 1'b1;
               if (walk_ff[TREE_W-1:0] == QUERY_LAST_WALK) begin
                  step_in  = CMB_QUAD;
                  state_in = ST_COMBINE;
               end else begin
                  walk_in  = walk_ff + WALK_W'(1);
                  state_in = ST_START;
               end
            end
         end
         ST_COMBINE: begin
            step_in = step_ff + STEP_W'(1);
            case (step_ff)
               CMB_QUAD: begin
                  mac_a  = coef_ff[2];
                  mac_c  = coef_ff[3];
                  acc_in = mac_y;
               end
               CMB_LIN: begin
                  mac_a  = acc_ff;
                  mac_c  = coef_ff[4];
                  acc_in = mac_y;
               end
               CMB_HALF: begin
                  acc_in = (acc_ff >> 1) + coef_ff[1] + coef_ff[5];
               end
               default: begin
                  mac_a = coef_ff[0];
                  mac_c = acc_ff;
                  if (!phase_ff) begin
                     phi_in   = mac_y;
                     phase_in = 1'b1;
                     walk_in  = '0;
                     state_in = ST_START;
                  end else begin
                     acc_in   = phi_ff - mac_y;
                     state_in = ST_FINISH;
                  end
               end
            endcase
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_sum_in   = acc_ff[SUM_W-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff    <= mode_in;
      walk_ff    <= walk_in;
      phase_ff   <= phase_in;
      step_ff    <= step_in;
      x_ff       <= x_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      val_ff     <= val_in;
      p1_ff      <= p1_in;
      p2_ff      <= p2_in;
      acc_ff     <= acc_in;
      phi_ff     <= phi_in;
      rsp_sum_ff <= rsp_sum_in;
      if (coef_we) begin
         coef_ff[walk_ff[TREE_W-1:0]] <= acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tree_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= tree_mem[mem_raddr];
   end

endmodule

`default_nettype wire

### verif/testbench.sv
// Testbench for progression_add_range_sum_fenwick: random and directed
// load / progression-add / range-sum words checked against an element-array model.
// Depends on pars_pkg and the block's RTL only.
`timescale 1ns / 1ps

module testbench;
   import pars_pkg::*;

   localparam int ARRAY_N = 1024;
   localparam int IDLE_LIMIT = 60000;   // longer than the whole clear sweep
   localparam int HOLD_CYCLES = 3000;
   localparam int TAIL_CYCLES = 400;    // lets the longest add finish
   localparam kind_type KIND_UNUSED = 2'd3;

   typedef struct {
      kind_type kind;
      logic [INDEX_W-1:0] low;
      logic [INDEX_W-1:0] high;
      logic [VALUE_W-1:0] value;
   } req_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   kind_type req_kind = KIND_LOAD;
   logic [INDEX_W-1:0] req_range_low = '0;
   logic [INDEX_W-1:0] req_range_high = '0;
   logic [VALUE_W-1:0] req_load_value = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [SUM_W-1:0] rsp_range_sum;

   req_word_type pending_words[$];
   logic [SUM_W-1:0] expected_sums[$];
   logic [DATA_W-1:0] element_values [1:ARRAY_N];

   logic req_took = 1'b0;
   int sender_idle_pct = 0;
   int receiver_idle_pct = 0;
   int hold_asked = 0;
   int hold_served = 0;
   int hold_left = 0;
   int idle_cycles = 0;
   int failures = 0;
   int n_loads = 0, n_adds = 0, n_sums = 0, n_ignored = 0;

   progression_add_range_sum_fenwick uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_kind(req_kind), .req_range_low(req_range_low),
      .req_range_high(req_range_high), .req_load_value(req_load_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_range_sum(rsp_range_sum)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Apply one accepted word to the element array; queue the sum a query yields.
   task automatic apply_word(input req_word_type w);
      int lo, hi;
      logic [DATA_W-1:0] total;
      lo = w.low;
      hi = w.high;
      total = '0;
      case (w.kind)
         KIND_LOAD: begin
            if (lo >= 1 && lo <= ARRAY_N) begin
               element_values[lo] += DATA_W'(w.value);
               n_loads++;
            end else n_ignored++;
         end
         KIND_ADD: begin
            // step is fixed at one: element k gains k - low + 1
            if (lo == 0 || lo > hi || hi > ARRAY_N) n_ignored++;
            else begin
               for (int k = lo; k <= hi; k++)
                  element_values[k] += DATA_W'(k - lo + 1);
               n_adds++;
            end
         end
         KIND_QUERY: begin
            // clamp high, read low 0 as 1; an empty range sums to zero
            if (hi > ARRAY_N) hi = ARRAY_N;
            if (lo == 0) lo = 1;
            for (int k = lo; k <= hi; k++) total += element_values[k];
            expected_sums = {expected_sums, total[SUM_W-1:0]};
         end
         default: n_ignored++;
      endcase
   endtask

   function automatic req_word_type make_word(input kind_type kind, input int low,
                                              input int high, input int value);
      req_word_type w;
      w.kind = kind;
      w.low = INDEX_W'(low);
      w.high = INDEX_W'(high);
      w.value = VALUE_W'(value);
      return w;
   endfunction

   // Append one word to the driver's queue.
   task automatic queue_word(input req_word_type w);
      pending_words = {pending_words, w};
   endtask

   // Mostly well-formed words on short ranges, with some full-width noise.
   function automatic req_word_type random_word();
      int pick, lo, hi;
      kind_type kind;
      pick = $urandom_range(0, 99);
      lo = $urandom_range(1, ARRAY_N);
      hi = lo + $urandom_range(0, 15);
      if ($urandom_range(0, 9) == 0) hi = lo + $urandom_range(0, ARRAY_N);
      if (hi > ARRAY_N) hi = ARRAY_N;
      if (pick < 20) kind = KIND_LOAD;
      else if (pick < 50) kind = KIND_ADD;
      else if (pick < 88) kind = KIND_QUERY;
      else if (pick < 91) kind = KIND_UNUSED;
      else begin
         kind = kind_type'($urandom_range(0, 3));
         lo = $urandom_range(0, 2047);
         hi = $urandom_range(0, 2047);
      end
      return make_word(kind, lo, hi, $urandom);
   endfunction

   // Driver: change inputs on the falling edge; hold a stalled word.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (pending_words.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            req_word_type w;
            w = pending_words.pop_front();
            req_valid <= 1'b1;
            req_kind <= w.kind;
            req_range_low <= w.low;
            req_range_high <= w.high;
            req_load_value <= w.value;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver stall: random, or a long hold-off counted here.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_asked != hold_served) begin
         hold_served = hold_asked;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
      end
   end

   // Monitor: sample at the rising edge, predict on request, check on response.
   always @(posedge clock) begin
      logic took, gave;
      took = !reset && req_valid && !req_stall;
      gave = !reset && rsp_valid && !rsp_stall;
      req_took <= took;
      if (took)
         apply_word(make_word(req_kind, req_range_low, req_range_high, req_load_value));
      if (gave) begin
         if (expected_sums.size() == 0) begin
            $display("%0t: unexpected rsp word, range_sum %0d", $time, rsp_range_sum);
            failures++;
         end else begin
            logic [SUM_W-1:0] want;
            want = expected_sums.pop_front();
            if (rsp_range_sum !== want) begin
               $display("%0t: range_sum mismatch, expected %0d, actual %0d",
                        $time, want, rsp_range_sum);
               failures++;
            end else n_sums++;
         end
      end
      // Watchdog: count cycles with no word moving on either channel.
      if (took || gave || reset) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Wait until every queued word is accepted and every sum has returned.
   task automatic drain();
      do begin
         @(posedge clock);
         #1;
      end while (pending_words.size() > 0 || expected_sums.size() > 0 ||
                 (req_valid && !req_took));
   endtask

   task automatic queue_random(input int count);
      repeat (count) queue_word(random_word());
   endtask

   initial begin
      for (int k = 1; k <= ARRAY_N; k++) element_values[k] = '0;
      repeat (3) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      // Phase one: sender idles lightly, receiver heavily; directed words first.
      sender_idle_pct = 27;
      receiver_idle_pct = 47;
      queue_word(make_word(KIND_LOAD, 1, 0, 20'hFFFFF));
      queue_word(make_word(KIND_LOAD, ARRAY_N, 2047, 20'hFFFFF));
      queue_word(make_word(KIND_LOAD, 512, 0, 0));
      queue_word(make_word(KIND_LOAD, 0, 5, 77));         // index zero
      queue_word(make_word(KIND_LOAD, ARRAY_N + 1, 5, 77)); // past end
      queue_word(make_word(KIND_LOAD, 2047, 5, 77));
      queue_word(make_word(KIND_ADD, 1, ARRAY_N, 0));
      queue_word(make_word(KIND_ADD, 5, 5, 0));
      queue_word(make_word(KIND_ADD, ARRAY_N, ARRAY_N, 0));
      queue_word(make_word(KIND_ADD, 0, 10, 0));       // low zero
      queue_word(make_word(KIND_ADD, 20, 10, 0));      // low above high
      queue_word(make_word(KIND_ADD, 10, 2047, 0));    // high past end
      queue_word(make_word(KIND_UNUSED, 1, ARRAY_N, 20'hFFFFF));
      queue_word(make_word(KIND_QUERY, 1, ARRAY_N, 0));
      queue_word(make_word(KIND_QUERY, 1, 1, 0));
      queue_word(make_word(KIND_QUERY, ARRAY_N, ARRAY_N, 0));
      queue_word(make_word(KIND_QUERY, 0, 2047, 20'hFFFFF)); // clamped
      queue_word(make_word(KIND_QUERY, 30, 4, 0));     // empty range
      queue_word(make_word(KIND_QUERY, 2047, 2047, 0));
      queue_word(make_word(KIND_QUERY, 3, 9, 0));
      queue_random(280);
      drain();
      // Sender pause: let a trailing load or add finish before moving on.
      repeat (TAIL_CYCLES) @(posedge clock);

      // Phase two: roles swapped.
      sender_idle_pct = 47;
      receiver_idle_pct = 27;
      queue_random(300);
      drain();

      // Phase three: no idling, after a long receiver hold-off to back up the block.
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      hold_asked++;
      queue_random(300);
      drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d loads, %0d progression adds, %0d range sums checked,",
               n_loads, n_adds, n_sums);
      $display("%0d ignored words, under three idle mixes and one long hold-off.",
               n_ignored);
      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
